FILE: design/ncc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ncc_pkg;
    localparam int NCH = 4;
    localparam int CHANNELS = 4;
    localparam int ACC_W = 56;
    localparam int THR_W = 41;
    localparam int BIAS_W = 21;
    localparam int PROD_W = 2 * ACC_W;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_BIAS = 1'b1;

    typedef struct packed {
        logic               last_pixel;
        logic signed [15:0] target_ch3;
        logic signed [15:0] target_ch2;
        logic signed [15:0] target_ch1;
        logic signed [15:0] target_ch0;
        logic signed [15:0] template_ch3;
        logic signed [15:0] template_ch2;
        logic signed [15:0] template_ch1;
        logic signed [15:0] template_ch0;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] ncc_ch3;
        logic signed [15:0] ncc_ch2;
        logic signed [15:0] ncc_ch1;
        logic signed [15:0] ncc_ch0;
        logic               success;
    } t_out_beat;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  a;
        logic [ACC_W-1:0]  b;
    } t_mul_req;
endpackage
`default_nettype wire

FILE: design/ncc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequential 56x56 multiplier: one 56x14 partial product per cycle.
module ncc_mul import ncc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mul_req          i_req,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_prod
);
    logic [ACC_W-1:0]  r_a;
    logic [ACC_W-1:0]  r_b;
    logic [PROD_W-1:0] r_acc;
    logic [2:0]        r_cnt;
    logic              r_busy;
    logic [69:0]       w_pp;

    assign w_pp = r_a * r_b[13:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= r_acc + ({{(PROD_W-70){1'b0}}, w_pp} << (7'd14 * {4'd0, r_cnt}));
                r_b   <= r_b >> 14;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_prod = r_acc;
endmodule
`default_nettype wire

FILE: design/normalized_cross_correlation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-channel normalized cross correlation. Ordinary pixel beats are
// accumulated as they arrive and the block stays ready. On the beat
// marked last_pixel the block stalls for a finishing pass. First, per
// channel, one energy product and compare. Then, per channel, a 56-step
// bit-serial square root, each step squaring the trial via the shared
// multiplier, and a 15-step restoring divide. The pass is bound by the
// shared multiplier; root and divide are skipped when every energy
// product is below the threshold. The result then waits in an output
// register while the next image streams in, but that image's last beat
// stalls until the result is taken.
module normalized_cross_correlation_unit import ncc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire t_in_beat          i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output t_out_beat              o_data,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [THR_W-1:0]  i_cfg_data
);
    typedef enum logic [7:0] {
        S_ACC  = 8'b0000_0001,
        S_PROD = 8'b0000_0010,
        S_PWT  = 8'b0000_0100,
        S_SQ   = 8'b0000_1000,
        S_SWT  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_NEXT = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic [THR_W-1:0]   r_thr;
    logic [BIAS_W-1:0]  r_bias;
    logic [ACC_W-1:0]   r_cross [NCH];
    logic [ACC_W-1:0]   r_te    [NCH];
    logic [ACC_W-1:0]   r_ie    [NCH];
    logic [PROD_W-1:0]  r_prod  [NCH];
    logic [1:0]         r_ch;
    logic               r_phase;   // 0: products, 1: root/divide
    logic               r_any;
    logic [5:0]         r_bit;
    logic [ACC_W-1:0]   r_root;
    logic [ACC_W-1:0]   r_cand;
    logic [ACC_W:0]     r_den;
    logic [ACC_W:0]     r_rem;
    logic [14:0]        r_q;
    logic [4:0]         r_step;
    logic [15:0]        r_ncc [NCH];
    logic               r_success;
    logic               r_ovalid;

    t_mul_req           w_req;
    logic               w_done;
    logic [PROD_W-1:0]  w_prod;
    logic signed [15:0] w_t [NCH];
    logic signed [15:0] w_s [NCH];
    logic               w_take;
    logic [ACC_W-1:0]   w_mag;
    logic               w_neg;
    logic [ACC_W+1:0]   w_rem2;

    ncc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    assign w_t[0] = i_data.template_ch0;
    assign w_t[1] = i_data.template_ch1;
    assign w_t[2] = i_data.template_ch2;
    assign w_t[3] = i_data.template_ch3;
    assign w_s[0] = i_data.target_ch0;
    assign w_s[1] = i_data.target_ch1;
    assign w_s[2] = i_data.target_ch2;
    assign w_s[3] = i_data.target_ch3;

    assign o_stall = (r_state != S_ACC) || (r_ovalid && i_data.last_pixel);
    assign w_take  = i_valid && !o_stall;

    assign w_neg  = r_cross[r_ch][ACC_W-1];
    assign w_mag  = w_neg ? (~r_cross[r_ch] + 1'b1) : r_cross[r_ch];
    assign w_rem2 = {r_rem, 1'b0};

    always_comb begin
        w_req.start = 1'b0;
        w_req.a     = r_te[r_ch];
        w_req.b     = r_ie[r_ch];
        if (r_state == S_PROD) begin
            w_req.start = 1'b1;
        end else if (r_state == S_SQ) begin
            w_req.start = 1'b1;
            w_req.a     = r_cand;
            w_req.b     = r_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACC;
            r_thr     <= THR_W'(64'd68719476736);
            r_bias    <= BIAS_W'(26844);
            r_ovalid  <= 1'b0;
            r_ch      <= '0;
            r_phase   <= 1'b0;
            r_any     <= 1'b0;
            r_success <= 1'b0;
            for (int k = 0; k < NCH; k++) begin
                r_cross[k] <= '0;
                r_te[k]    <= '0;
                r_ie[k]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_THRESHOLD: r_thr  <= i_cfg_data;
                    REG_BIAS:      r_bias <= i_cfg_data[BIAS_W-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_ACC: begin
                    if (w_take) begin
                        for (int k = 0; k < CHANNELS; k++) begin
                            r_cross[k] <= r_cross[k] + ACC_W'(w_t[k] * w_s[k]);
                            r_te[k]    <= r_te[k] + ACC_W'(w_t[k] * w_t[k]);
                            r_ie[k]    <= r_ie[k] + ACC_W'(w_s[k] * w_s[k]);
                        end
                        if (i_data.last_pixel) begin
                            r_state <= S_PROD;
                            r_ch    <= '0;
                            r_phase <= 1'b0;
                            r_any   <= 1'b0;
                        end
                    end
                end
                S_PROD: r_state <= S_PWT;
                S_PWT: begin
                    if (w_done) begin
                        r_prod[r_ch] <= w_prod;
                        if (r_thr == '0 || w_prod >= {{(PROD_W-THR_W){1'b0}}, r_thr})
                            r_any <= 1'b1;
                        r_state <= S_NEXT;
                    end
                end
                S_SQ: r_state <= S_SWT;
                S_SWT: begin
                    if (w_done) begin
                        if (w_prod <= r_prod[r_ch]) r_root <= r_cand;
                        if (r_bit == 6'd0) begin
                            r_state <= S_DIV;
                            r_step  <= '0;
                            r_q     <= '0;
                            r_den   <= {1'b0, (w_prod <= r_prod[r_ch]) ? r_cand : r_root}
                                       + {{(ACC_W+1-BIAS_W){1'b0}}, r_bias};
                            r_rem   <= {1'b0, w_mag};
                        end else begin
                            r_bit   <= r_bit - 6'd1;
                            r_cand  <= ((w_prod <= r_prod[r_ch]) ? r_cand : r_root)
                                       | (ACC_W'(1) << (r_bit - 6'd1));
                            r_state <= S_SQ;
                        end
                    end
                end
                S_DIV: begin
                    if (r_step == 5'd0) begin
                        if (w_mag == '0) begin
                            r_ncc[r_ch] <= '0;
                            r_state     <= S_NEXT;
                        end else if (r_den == '0 || {1'b0, w_mag} >= r_den) begin
                            r_ncc[r_ch] <= w_neg ? 16'h8000 : 16'h7FFF;
                            r_state     <= S_NEXT;
                        end else begin
                            r_step <= 5'd1;
                        end
                    end else if (r_step <= 5'd15) begin
                        if (w_rem2 >= {1'b0, r_den}) begin
                            r_rem <= (ACC_W+1)'(w_rem2 - {1'b0, r_den});
                            r_q   <= {r_q[13:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2[ACC_W:0];
                            r_q   <= {r_q[13:0], 1'b0};
                        end
                        r_step <= r_step + 5'd1;
                    end else begin
                        r_ncc[r_ch] <= w_neg ? (16'd0 - {1'b0, r_q}) : {1'b0, r_q};
                        r_state     <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_ch != 2'(CHANNELS - 1)) begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= r_phase ? S_SQ : S_PROD;
                        r_bit   <= 6'(ACC_W - 1);
                        r_root  <= '0;
                        r_cand  <= ACC_W'(1) << (ACC_W - 1);
                    end else if (!r_phase && r_any) begin
                        r_phase <= 1'b1;
                        r_ch    <= '0;
                        r_state <= S_SQ;
                        r_bit   <= 6'(ACC_W - 1);
                        r_root  <= '0;
                        r_cand  <= ACC_W'(1) << (ACC_W - 1);
                    end else begin
                        if (!r_phase)
                            for (int k = 0; k < NCH; k++) r_ncc[k] <= '0;
                        r_success <= r_phase;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        o_data.success <= r_success;
                        o_data.ncc_ch0 <= r_ncc[0];
                        o_data.ncc_ch1 <= r_ncc[1];
                        o_data.ncc_ch2 <= r_ncc[2];
                        o_data.ncc_ch3 <= r_ncc[3];
                        for (int k = 0; k < NCH; k++) begin
                            r_cross[k] <= '0;
                            r_te[k]    <= '0;
                            r_ie[k]    <= '0;
                        end
                        r_state <= S_ACC;
                    end
                end
                default: r_state <= S_ACC;
            endcase
        end
    end
    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

FILE: bench/normalized_cross_correlation_unit_tb.sv
`timescale 1ns / 1ps
module normalized_cross_correlation_unit_tb;
    import ncc_pkg::*;

    localparam int  SETTLE_CYCLES = 1500;   // one full finishing pass and margin
    localparam int  LONG_HOLD = 4000;
    localparam int  PHASE_ITEMS = 440;
    localparam logic [THR_W-1:0]  THR_MAX = 41'h100_0000_0000;
    localparam logic [BIAS_W-1:0] BIAS_MAX = 21'h10_0000;

    typedef enum int { PAT_FULL, PAT_TINY, PAT_MIRROR, PAT_SPARSE } t_pattern;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_beat   i_data;
    logic       o_valid;
    logic       i_stall;
    t_out_beat  o_data;
    logic       i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [THR_W-1:0] i_cfg_data;

    normalized_cross_correlation_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the block
    logic [THR_W-1:0]  thr_shadow;
    logic [BIAS_W-1:0] bias_shadow;
    logic [ACC_W-1:0]  cross_acc [NCH];
    logic [ACC_W-1:0]  tmpl_nrg [NCH];
    logic [ACC_W-1:0]  targ_nrg [NCH];

    t_in_beat  pixel_q [$];
    t_out_beat ncc_q [$];
    int        errors = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    bit        hold_req = 0;
    int        hold_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [ACC_W-1:0] isqrt_prod(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
        logic [PROD_W-1:0] p;
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] c;
        p = PROD_W'(a) * PROD_W'(b);
        r = '0;
        for (int bt = ACC_W - 1; bt >= 0; bt--) begin
            c = r | (PROD_W'(1) << bt);
            if (c * c <= p) r = c;
        end
        return r[ACC_W-1:0];
    endfunction

    function automatic logic [15:0] divide_q15(logic [ACC_W-1:0] x, logic [63:0] den);
        logic       neg;
        logic [63:0] mag;
        logic [63:0] rem;
        logic [15:0] q;
        neg = x[ACC_W-1];
        mag = neg ? 64'(-x) : 64'(x);
        mag = mag & {8'h0, {ACC_W{1'b1}}};
        if (mag == 0) return 16'h0000;
        if (den == 0 || mag >= den) return neg ? 16'h8000 : 16'h7FFF;
        rem = mag;
        q = '0;
        for (int i = 0; i < 15; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return neg ? -q : q;
    endfunction

    task automatic predict_ncc(input t_in_beat b);
        logic signed [15:0] tv [NCH];
        logic signed [15:0] sv [NCH];
        logic signed [31:0] p;
        logic               all_zero;
        logic [PROD_W-1:0]  nrg_prod;
        logic [15:0]        v [NCH];
        t_out_beat          r;
        tv = '{b.template_ch0, b.template_ch1, b.template_ch2, b.template_ch3};
        sv = '{b.target_ch0, b.target_ch1, b.target_ch2, b.target_ch3};
        for (int k = 0; k < CHANNELS; k++) begin
            p = tv[k] * sv[k];
            cross_acc[k] = cross_acc[k] + {{(ACC_W-32){p[31]}}, p};
            p = tv[k] * tv[k];
            tmpl_nrg[k] = tmpl_nrg[k] + {{(ACC_W-32){p[31]}}, p};
            p = sv[k] * sv[k];
            targ_nrg[k] = targ_nrg[k] + {{(ACC_W-32){p[31]}}, p};
        end
        if (!b.last_pixel) return;
        all_zero = 1'b1;
        for (int k = 0; k < CHANNELS; k++) begin
            nrg_prod = PROD_W'(tmpl_nrg[k]) * PROD_W'(targ_nrg[k]);
            if (thr_shadow == 0 || nrg_prod >= PROD_W'(thr_shadow)) all_zero = 1'b0;
        end
        for (int k = 0; k < NCH; k++) begin
            v[k] = '0;
            if (!all_zero && k < CHANNELS)
                v[k] = divide_q15(cross_acc[k],
                                  64'(isqrt_prod(tmpl_nrg[k], targ_nrg[k])) + 64'(bias_shadow));
        end
        r.success = ~all_zero;
        r.ncc_ch0 = v[0];
        r.ncc_ch1 = v[1];
        r.ncc_ch2 = v[2];
        r.ncc_ch3 = v[3];
        ncc_q = {ncc_q, r};
        for (int k = 0; k < NCH; k++) begin
            cross_acc[k] = '0;
            tmpl_nrg[k] = '0;
            targ_nrg[k] = '0;
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_ncc(i_data);
            if (!i_valid || !o_stall) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_data <= pixel_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (ncc_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_data);
                end else begin
                    e = ncc_q.pop_front();
                    if (o_data.success !== e.success) begin
                        errors++;
                        $display("%0t: success expected %b actual %b",
                                 $time, e.success, o_data.success);
                    end
                    if (o_data.ncc_ch0 !== e.ncc_ch0) begin
                        errors++;
                        $display("%0t: ncc_ch0 expected %0d actual %0d",
                                 $time, e.ncc_ch0, o_data.ncc_ch0);
                    end
                    if (o_data.ncc_ch1 !== e.ncc_ch1) begin
                        errors++;
                        $display("%0t: ncc_ch1 expected %0d actual %0d",
                                 $time, e.ncc_ch1, o_data.ncc_ch1);
                    end
                    if (o_data.ncc_ch2 !== e.ncc_ch2) begin
                        errors++;
                        $display("%0t: ncc_ch2 expected %0d actual %0d",
                                 $time, e.ncc_ch2, o_data.ncc_ch2);
                    end
                    if (o_data.ncc_ch3 !== e.ncc_ch3) begin
                        errors++;
                        $display("%0t: ncc_ch3 expected %0d actual %0d",
                                 $time, e.ncc_ch3, o_data.ncc_ch3);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    task automatic add_pixel(t_in_beat b);
        pixel_q = {pixel_q, b};
    endtask

    function automatic t_in_beat pixel_pair(logic signed [15:0] t, logic signed [15:0] s,
                                            logic last);
        t_in_beat b;
        b.template_ch0 = t; b.template_ch1 = t; b.template_ch2 = t; b.template_ch3 = t;
        b.target_ch0 = s;   b.target_ch1 = s;   b.target_ch2 = s;   b.target_ch3 = s;
        b.last_pixel = last;
        return b;
    endfunction

    function automatic logic [15:0] rand_sample(t_pattern pat);
        case (pat)
            PAT_TINY:   return 16'($urandom_range(0, 6)) - 16'd3;
            PAT_SPARSE: return ($urandom_range(1) != 0) ? 16'h0000 : 16'($urandom);
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic queue_image(int n);
        t_pattern   pat;
        t_in_beat   b;
        logic [15:0] t [NCH];
        logic [15:0] s [NCH];
        pat = t_pattern'($urandom_range(3));
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < NCH; k++) begin
                t[k] = rand_sample(pat);
                s[k] = rand_sample(pat);
                if (pat == PAT_MIRROR) s[k] = ($urandom_range(1) != 0) ? t[k] : -t[k];
            end
            b.template_ch0 = t[0]; b.template_ch1 = t[1];
            b.template_ch2 = t[2]; b.template_ch3 = t[3];
            b.target_ch0 = s[0];   b.target_ch1 = s[1];
            b.target_ch2 = s[2];   b.target_ch3 = s[3];
            b.last_pixel = (i == n - 1);
            add_pixel(b);
        end
    endtask

    task automatic write_reg(logic [0:0] idx, logic [THR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == REG_THRESHOLD) thr_shadow = val;
        else bias_shadow = BIAS_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || i_valid || ncc_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(bit with_hold);
        int fed;
        int n;
        fed = 0;
        while (fed < PHASE_ITEMS) begin
            n = ($urandom_range(99) < 5) ? $urandom_range(32, 200) : $urandom_range(1, 8);
            queue_image(n);
            fed += n;
            if (with_hold && fed > PHASE_ITEMS / 2) begin
                with_hold = 0;
                hold_req = 1;
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_THRESHOLD;
        i_cfg_data = '0;
        thr_shadow = 41'h10_0000_0000;
        bias_shadow = 21'd26844;
        for (int k = 0; k < NCH; k++) begin
            cross_acc[k] = '0;
            tmpl_nrg[k] = '0;
            targ_nrg[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 20;
        recv_idle = 58;
        // directed: extremes, all-zero energies, perfect and inverted match
        add_pixel(pixel_pair(16'sh7FFF, 16'sh7FFF, 1'b1));
        add_pixel(pixel_pair(-16'sh8000, -16'sh8000, 1'b1));
        add_pixel(pixel_pair(16'sh7FFF, -16'sh8000, 1'b1));
        add_pixel(pixel_pair(16'sh0000, 16'sh0000, 1'b1));
        add_pixel(pixel_pair(16'sh0001, 16'sh0001, 1'b1));
        add_pixel(pixel_pair(16'sh4000, 16'sh4000, 1'b0));
        add_pixel(pixel_pair(-16'sh4000, -16'sh4000, 1'b0));
        add_pixel(pixel_pair(16'sh2000, -16'sh2000, 1'b1));
        add_pixel(pixel_pair(16'sh1234, 16'sh0000, 1'b1));
        add_pixel(pixel_pair(-16'sh0001, 16'sh7FFF, 1'b0));
        add_pixel(pixel_pair(16'sh5555, -16'sh2AAB, 1'b1));
        queue_image(4);
        drain();

        // no threshold, no bias: zero denominator and saturation
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_BIAS, '0);
        add_pixel(pixel_pair(16'sh0000, 16'sh0000, 1'b1));
        add_pixel(pixel_pair(16'sh0100, 16'sh0100, 1'b1));
        add_pixel(pixel_pair(16'sh0100, -16'sh0100, 1'b1));
        random_phase(1);

        send_idle = 58;
        recv_idle = 20;
        write_reg(REG_THRESHOLD, THR_MAX);
        write_reg(REG_BIAS, THR_W'(BIAS_MAX));
        random_phase(0);

        write_reg(REG_THRESHOLD, THR_W'({$urandom_range(0, 255), $urandom} & THR_MAX - 1));
        write_reg(REG_BIAS, THR_W'($urandom_range(0, 1048576)));
        random_phase(0);

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_THRESHOLD, 41'h10_0000_0000);
        write_reg(REG_BIAS, THR_W'(26844));
        random_phase(0);

        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #300_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule

FILE: normalized_cross_correlation_unit.f
design/ncc_pkg.sv
design/ncc_mul.sv
design/normalized_cross_correlation_unit.sv
bench/normalized_cross_correlation_unit_tb.sv
